[hdl/pqwd_pkg.sv]
`timescale 1ns / 1ps

package pqwd_pkg;

   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_NUM_WORKERS = 4;

   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 16;
   localparam int BUSY_W   = 4;
   localparam int WIDX_W   = 2;
   localparam int QCNT_W   = 6;
   localparam int ENTRY_W  = HANDLE_W + PRIO_W;

   typedef enum logic {
      OP_ENQUEUE  = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_ENQUEUED   = 3'd0,
      ST_FULL       = 3'd1,
      ST_DISPATCHED = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_PAUSED     = 3'd4,
      ST_NO_WORKER  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [HANDLE_W-1:0] job_handle;
      logic [PRIO_W-1:0]   job_priority;
      logic [BUSY_W-1:0]   worker_busy;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] dispatched_handle;
      logic [WIDX_W-1:0]   worker_index;
      logic [QCNT_W-1:0]   queue_count;
   } rsp_type;

endpackage

[hdl/pqwd_ram.sv]
`timescale 1ns / 1ps

module pqwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/priority_queue_worker_dispatch.sv]
`timescale 1ns / 1ps
// Enqueue and refused dispatch register their result at the accepting edge.
// Dispatch: a serial priority scan over the queued entries, then the entries behind the
// winner move down one by one to close the gap, then a closing step; one RAM port.
// The result strobe is registered at the end of the closing step; a new transaction can start while it is shown.
// Reset (synchronous, active high) empties the queue and clears paused; RAM content is kept.
// The receiver cannot stall: rsp_valid is a single-cycle strobe.

module priority_queue_worker_dispatch
   import pqwd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_WORKERS = DEF_NUM_WORKERS
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   // result channel
   output logic    rsp_valid,
   output rsp_type rsp_data,
   // control register (paused)
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = CNT_W + 1;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               paused_ff, paused_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;    // entry whose data arrives from the RAM
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;  // scan winner, then the shift pointer
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [HANDLE_W-1:0] best_handle_ff, best_handle_in;
   logic [WIDX_W-1:0]   worker_ff, worker_in;
   rsp_type             rsp_ff, rsp_in;

   // RAM port
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // first idle worker
   logic              idle_found;
   logic [WIDX_W-1:0] idle_worker;

   // entry store: {handle, priority}, one write and one registered read per cycle
   pqwd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // priority encoder over the busy mask, limited to the workers that exist
   always_comb begin
      idle_found  = 1'b0;
      idle_worker = '0;
      for (int w = 0; w < BUSY_W; w++) begin
         if (w < NUM_WORKERS && !req_data.worker_busy[w] && !idle_found) begin
            idle_found  = 1'b1;
            idle_worker = WIDX_W'(w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_prio_ff   <= best_prio_in;
      best_handle_ff <= best_handle_in;
      worker_ff      <= worker_in;
      rsp_ff         <= rsp_in;
   end

   // sequencer
   always_comb begin
      logic [EXT_W-1:0]    count_ext;
      logic [EXT_W-1:0]    cmp_ext;
      logic [EXT_W-1:0]    shift_ext;
      logic [PRIO_W-1:0]   rd_prio;
      logic [HANDLE_W-1:0] rd_handle;
      logic                take;
      logic [IDX_W-1:0]    best_idx_nx;

      count_ext   = EXT_W'(count_ff);
      cmp_ext     = EXT_W'(cmp_idx_ff);
      shift_ext   = EXT_W'(best_idx_ff);
      rd_prio     = ram_rd_data[PRIO_W-1:0];
      rd_handle   = ram_rd_data[ENTRY_W-1:PRIO_W];
      take        = 1'b0;
      best_idx_nx = best_idx_ff;

      state_in       = state_ff;
      count_in       = count_ff;
      paused_in      = paused_ff;
      rsp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      best_idx_in    = best_idx_ff;
      best_prio_in   = best_prio_ff;
      best_handle_in = best_handle_ff;
      worker_in      = worker_ff;
      rsp_in         = rsp_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = {req_data.job_handle, req_data.job_priority};
      ram_rd_addr = '0;

      if (csr_valid) begin
         paused_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.dispatched_handle = '0;
               rsp_in.worker_index      = '0;
               rsp_valid_in             = 1'b1;
               if (req_data.op == OP_ENQUEUE) begin
                  if (count_ext >= EXT_W'(QUEUE_DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ram_wr_en     = 1'b1;
                     count_in      = CNT_W'(count_ext + 1'b1);
                     rsp_in.status = ST_ENQUEUED;
                  end
               end else if (paused_ff) begin
                  rsp_in.status = ST_PAUSED;
               end else if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else if (!idle_found) begin
                  rsp_in.status = ST_NO_WORKER;
               end else begin
                  // start the scan: entry 0 is read now, compared next cycle
                  rsp_valid_in = 1'b0;
                  worker_in    = idle_worker;
                  cmp_idx_in   = '0;
                  ram_rd_addr  = '0;
                  state_in     = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // strict greater-than keeps the earliest entry on a tie
            take = (cmp_idx_ff == '0) || (rd_prio > best_prio_ff);
            if (take) begin
               best_idx_nx    = cmp_idx_ff;
               best_prio_in   = rd_prio;
               best_handle_in = rd_handle;
            end
            best_idx_in = best_idx_nx;
            if (cmp_ext + 1'b1 == count_ext) begin
               // last entry seen: fetch the one behind the winner
               ram_rd_addr = IDX_W'(best_idx_nx + 1'b1);
               state_in    = S_SHIFT;
            end else begin
               ram_rd_addr = IDX_W'(cmp_idx_ff + 1'b1);
               cmp_idx_in  = IDX_W'(cmp_idx_ff + 1'b1);
            end
         end

         S_SHIFT: begin
            if (shift_ext + 1'b1 < count_ext) begin
               // move entry i+1 down to i, prefetch i+2
               ram_wr_en   = 1'b1;
               ram_wr_addr = best_idx_ff;
               ram_wr_data = ram_rd_data;
               ram_rd_addr = IDX_W'(best_idx_ff + 2'd2);
               best_idx_in = IDX_W'(best_idx_ff + 1'b1);
            end else begin
               count_in                 = CNT_W'(count_ext - 1'b1);
               rsp_valid_in             = 1'b1;
               rsp_in.status            = ST_DISPATCHED;
               rsp_in.dispatched_handle = best_handle_ff;
               rsp_in.worker_index      = worker_ff;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.queue_count = QCNT_W'(count_in);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

[tb/pqwd_dispatch_checker.sv]
`timescale 1ns / 1ps

module pqwd_dispatch_checker
   import pqwd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_WORKERS = DEF_NUM_WORKERS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_data,
   output int      error_count,
   output int      results_pending
);

   logic [HANDLE_W-1:0] held_handle [QUEUE_DEPTH];
   logic [PRIO_W-1:0]   held_prio   [QUEUE_DEPTH];
   int                  held_count;
   logic                dispatch_paused;
   rsp_type             results_due [$];

   initial begin
      error_count     = 0;
      results_pending = 0;
      held_count      = 0;
      dispatch_paused = 1'b0;
   end

   // Applies one job transaction to the shadow queue, returns the status it earns.
   function automatic rsp_type serve_job(req_type job);
      rsp_type res;
      int      worker;
      int      best;
      int      w;
      int      i;
      res    = '0;
      worker = -1;
      best   = 0;
      if (job.op == OP_ENQUEUE) begin
         if (held_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            held_handle[held_count] = job.job_handle;
            held_prio[held_count]   = job.job_priority;
            held_count++;
            res.status = ST_ENQUEUED;
         end
      end else if (dispatch_paused) begin
         res.status = ST_PAUSED;
      end else if (held_count == 0) begin
         res.status = ST_EMPTY;
      end else begin
         for (w = 0; w < NUM_WORKERS && w < BUSY_W; w++) begin
            if (worker < 0 && !job.worker_busy[w])
               worker = w;
         end
         if (worker < 0) begin
            res.status = ST_NO_WORKER;
         end else begin
            // strict compare keeps the earliest entry on ties
            for (i = 1; i < held_count; i++) begin
               if (held_prio[i] > held_prio[best])
                  best = i;
            end
            res.dispatched_handle = held_handle[best];
            res.worker_index      = worker[WIDX_W-1:0];
            for (i = best; i + 1 < held_count; i++) begin
               held_handle[i] = held_handle[i + 1];
               held_prio[i]   = held_prio[i + 1];
            end
            held_count--;
            res.status = ST_DISPATCHED;
         end
      end
      res.queue_count = held_count[QCNT_W-1:0];
      return res;
   endfunction

   task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type want;
      if (results_due.size() == 0) begin
         error_count++;
         $display("%0t: result with none expected, expected nothing, got %h", $time, got);
      end else begin
         want = results_due.pop_front();
         if (got.status !== want.status)
            flag_field("status", 32'(want.status), 32'(got.status));
         if (got.dispatched_handle !== want.dispatched_handle)
            flag_field("dispatched_handle", 32'(want.dispatched_handle),
                       32'(got.dispatched_handle));
         if (got.worker_index !== want.worker_index)
            flag_field("worker_index", 32'(want.worker_index), 32'(got.worker_index));
         if (got.queue_count !== want.queue_count)
            flag_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count      = 0;
         dispatch_paused = 1'b0;
         results_due.delete();
      end else begin
         if (rsp_valid)
            compare_result(rsp_data);
         if (csr_valid && csr_ready)
            dispatch_paused = csr_data;
         if (start && !busy)
            results_due.insert(results_due.size(), serve_job(req_data));
      end
      results_pending = results_due.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the priority job queue. A checker beside the block
// watches every transaction, keeps a shadow queue and compares each result.
module tb;
   import pqwd_pkg::*;

   localparam int REQ_W = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;
   int      error_count;
   int      results_pending;

   priority_queue_worker_dispatch u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   pqwd_dispatch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the run does not finish.
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic req_type make_job(op_type op, logic [HANDLE_W-1:0] handle,
                                        logic [PRIO_W-1:0] prio, logic [BUSY_W-1:0] mask);
      req_type job;
      job.op           = op;
      job.job_handle   = handle;
      job.job_priority = prio;
      job.worker_busy  = mask;
      return job;
   endfunction

   // enq_pct sets the enqueue share; low priorities are common so ties show up.
   function automatic req_type random_job(int enq_pct);
      req_type job;
      job.op           = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH;
      job.job_handle   = 16'($urandom());
      job.job_priority = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3))
                                                     : 16'($urandom());
      job.worker_busy  = ($urandom_range(0, 5) == 0) ? 4'hF : 4'($urandom());
      return job;
   endfunction

   // Drive at the falling edge; busy is stable there, so the transaction is
   // taken at the next rising edge once busy reads low. start stays high on
   // return so back-to-back transactions need no extra cycle.
   task automatic issue_job(req_type job);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= job;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Sender gap: start low for the given cycles, junk on the payload.
   task automatic hold_off(int cycles);
      logic [REQ_W-1:0] junk;
      junk = REQ_W'({$urandom(), $urandom()});
      @(negedge clock);
      start    <= 1'b0;
      req_data <= junk;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back, then settle.
   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // The paused register is only touched with the block idle.
   task automatic set_paused(logic value);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_data  <= 1'($urandom());
   endtask

   initial begin
      int phase;
      int n;
      int enq_pct;
      int burst_left;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // dispatch with nothing queued
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));
      // paused wins over empty; enqueues still go in while paused
      set_paused(1'b1);
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));
      issue_job(make_job(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 4'hF));
      issue_job(make_job(OP_ENQUEUE, 16'h0000, 16'h0000, 4'h0));
      issue_job(make_job(OP_DISPATCH, 16'hFFFF, 16'hFFFF, 4'h0));
      set_paused(1'b0);
      // every worker busy: queue must stay as it is
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'hF));
      // tie at top priority with the head entry, head must go first
      issue_job(make_job(OP_ENQUEUE, 16'h1234, 16'hFFFF, 4'h0));
      issue_job(make_job(OP_ENQUEUE, 16'hA5A5, 16'h8000, 4'h5));
      // walk the free worker from 3 down to 0
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'b0111));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'b1011));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'b1101));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'b1110));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));
      // winner in the middle: the entries behind it close up in order
      issue_job(make_job(OP_ENQUEUE, 16'h0001, 16'h0005, 4'h0));
      issue_job(make_job(OP_ENQUEUE, 16'h0002, 16'h0009, 4'h0));
      issue_job(make_job(OP_ENQUEUE, 16'h0003, 16'h0005, 4'h0));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));
      issue_job(make_job(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0));

      // --- random phases ---
      // Enqueue-heavy phases run the queue into full, dispatch-heavy ones
      // empty it; the paused phases pile up entries for the next one.
      // Each phase change drains all results before the register write.
      for (phase = 0; phase < 8; phase++) begin
         set_paused(phase % 4 == 1);
         case (phase % 4)
            0: enq_pct = 85;
            1: enq_pct = 60;
            2: enq_pct = 45;
            default: enq_pct = 25;
         endcase
         burst_left = 0;
         for (n = 0; n < 104; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // phase 2 runs flat out, no sender gaps at all
               if (phase != 2 && $urandom_range(0, 2) != 0)
                  hold_off($urandom_range(1, 12));
            end
            issue_job(random_job(enq_pct));
            burst_left--;
         end
      end

      wait_quiet();
      if (error_count == 0 && results_pending == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
